// ----- hdl/cone_support_point_core_macros.svh -----
`ifndef CONE_SUPPORT_POINT_CORE_MACROS_SVH
`define CONE_SUPPORT_POINT_CORE_MACROS_SVH

// same-cycle implication, reset aborts the check
`define CSP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication after a fixed number of cycles
`define CSP_ASSERT_LAT(lbl, ante, cons, n, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error(msg);

`endif

// ----- hdl/csp_pkg.sv -----
package csp_pkg;

	// port widths
	localparam int DIR_W    = 32;
	localparam int MARGIN_W = 31;
	localparam int CFG_W    = 31;
	localparam int SINE_W   = 17;
	localparam int PT_W     = 32;
	localparam int CASE_W   = 2;
	localparam int IDX_W    = 2;

	// register indexes
	localparam logic [IDX_W-1:0] REG_RADIUS      = 2'd0;
	localparam logic [IDX_W-1:0] REG_HALF_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_SINE        = 2'd2;

	// register reset values
	localparam logic [CFG_W-1:0]  RADIUS_RST = 31'd65536;
	localparam logic [CFG_W-1:0]  HH_RST     = 31'd65536;
	localparam logic [SINE_W-1:0] SINE_RST   = 17'd29309;

	// result case codes
	localparam logic [CASE_W-1:0] CASE_APEX  = 2'd0;
	localparam logic [CASE_W-1:0] CASE_RIM   = 2'd1;
	localparam logic [CASE_W-1:0] CASE_AXIAL = 2'd2;

	// datapath widths
	localparam int SQ_W    = 64;   // squared lengths
	localparam int NORM_W  = 62;   // normalized radicand
	localparam int SH_W    = 6;    // numerator shift 30+e
	localparam int ROOT_W  = 31;   // integer root, one bit per stage
	localparam int NUM_W   = 62;   // divide numerator
	localparam int QUO_W   = 32;   // quotient, one bit per stage
	localparam int UNIT_W  = 31;   // capped Q1.30 unit component
	localparam logic [UNIT_W-1:0] UNIT_ONE = 31'h4000_0000;

	localparam int NORM_LANES = 2;  // projected and full length
	localparam int DIV_LANES  = 5;  // rim x,z then margin x,y,z

	// per-word flags riding along the root and divide pipes
	typedef struct packed {
		logic                sx;
		logic                sy;
		logic                sz;
		logic                apex;
		logic                p2_nz;
		logic                l2_nz;
		logic [MARGIN_W-1:0] margin;
	} side_t;

	localparam int SIDE_W = $bits(side_t);

	typedef struct packed {
		side_t                             side;
		logic [DIV_LANES-1:0][NUM_W-1:0]   num;
	} root_tag_t;

	localparam int ROOT_TAG_W = $bits(root_tag_t);

endpackage

// ----- hdl/cone_support_point_core.sv -----
// Cone support point unit, Q16.16. One word is taken in every clock cycle
// (busy stays low) and its result comes out after the front stages of squaring,
// apex test and normalization, the root extraction pipe (one root bit per
// stage), the division pipe (one quotient bit per stage) and the back stages
// of scaling, summing and saturation. Results come in the order the words
// went in, each shown for one cycle with done high; the receiver cannot hold
// them off, so it must take every one. Write the configuration registers only
// when no word is in flight.
`include "cone_support_point_core_macros.svh"

module cone_support_point_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// command side
	input  logic                                start,
	output logic                                busy,
	input  logic signed [csp_pkg::DIR_W-1:0]    dir_x,
	input  logic signed [csp_pkg::DIR_W-1:0]    dir_y,
	input  logic signed [csp_pkg::DIR_W-1:0]    dir_z,
	input  logic [csp_pkg::MARGIN_W-1:0]        margin,
	// result side
	output logic                                done,
	output logic signed [csp_pkg::PT_W-1:0]     point_x,
	output logic signed [csp_pkg::PT_W-1:0]     point_y,
	output logic signed [csp_pkg::PT_W-1:0]     point_z,
	output logic [csp_pkg::CASE_W-1:0]          case_taken,
	// configuration
	input  logic                                wr_en,
	input  logic [csp_pkg::IDX_W-1:0]           wr_index,
	input  logic [csp_pkg::CFG_W-1:0]           wr_data
);
	import csp_pkg::*;

	localparam int SIN2_W = 2 * SINE_W;
	localparam int RHS_W  = SIN2_W + 32;
	localparam int CMP_W  = RHS_W + 32;
	localparam int PROD_W = CFG_W + UNIT_W;
	localparam int VAL_W  = 33;
	localparam int SUM_W  = 35;
	localparam int LAT    = 5 + ROOT_W + QUO_W + 3;

	function automatic logic [DIR_W-1:0] mag_of(input logic [DIR_W-1:0] v);
		return v[DIR_W-1] ? (~v + DIR_W'(1)) : v;
	endfunction

	function automatic logic [PT_W-1:0] sat_pt(input logic [SUM_W-1:0] v);
		if ((&v[SUM_W-1:PT_W-1]) || !(|v[SUM_W-1:PT_W-1])) begin
			return v[PT_W-1:0];
		end else if (v[SUM_W-1]) begin
			return {1'b1, {(PT_W-1){1'b0}}};
		end else begin
			return {1'b0, {(PT_W-1){1'b1}}};
		end
	endfunction

	function automatic logic [NUM_W-1:0] num_of(input logic [DIR_W-1:0] m,
		input logic [SH_W-1:0] s);
		logic [SQ_W-1:0] w;
		w = {{(SQ_W-DIR_W){1'b0}}, m} << s;
		return w[NUM_W-1:0];
	endfunction

	// configuration registers
	logic [CFG_W-1:0]  radius_q;
	logic [CFG_W-1:0]  half_height_q;
	logic [SINE_W-1:0] sine_q;
	logic [SIN2_W-1:0] sin2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q      <= RADIUS_RST;
			half_height_q <= HH_RST;
			sine_q        <= SINE_RST;
			sin2_q        <= SIN2_W'(SINE_RST) * SIN2_W'(SINE_RST);
		end else begin
			sin2_q <= SIN2_W'(sine_q) * SIN2_W'(sine_q);
			if (wr_en) begin
				unique case (wr_index)
					REG_RADIUS:      radius_q      <= wr_data;
					REG_HALF_HEIGHT: half_height_q <= wr_data;
					REG_SINE:        sine_q        <= wr_data[SINE_W-1:0];
					default: ;
				endcase
			end
		end
	end

	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// valid bits of the front and back stages
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic v_div;

	// stage 1: input word
	logic [DIR_W-1:0]    x_s1, y_s1, z_s1;
	logic [MARGIN_W-1:0] margin_s1;

	always_ff @(posedge clk) begin
		x_s1      <= dir_x;
		y_s1      <= dir_y;
		z_s1      <= dir_z;
		margin_s1 <= margin;
	end

	// stage 2: magnitudes and squares
	logic [DIR_W-1:0]    ax_s2, ay_s2, az_s2;
	logic [SQ_W-1:0]     ax2_s2, ay2_s2, az2_s2;
	logic                sx_s2, sy_s2, sz_s2;
	logic [MARGIN_W-1:0] margin_s2;
	logic [DIR_W-1:0]    ax_c, ay_c, az_c;

	assign ax_c = mag_of(x_s1);
	assign ay_c = mag_of(y_s1);
	assign az_c = mag_of(z_s1);

	always_ff @(posedge clk) begin
		ax_s2     <= ax_c;
		ay_s2     <= ay_c;
		az_s2     <= az_c;
		ax2_s2    <= SQ_W'(ax_c) * SQ_W'(ax_c);
		ay2_s2    <= SQ_W'(ay_c) * SQ_W'(ay_c);
		az2_s2    <= SQ_W'(az_c) * SQ_W'(az_c);
		sx_s2     <= x_s1[DIR_W-1];
		sy_s2     <= y_s1[DIR_W-1];
		sz_s2     <= z_s1[DIR_W-1];
		margin_s2 <= margin_s1;
	end

	// stage 3: projected and full squared lengths
	logic [SQ_W-1:0]     p2_s3, l2_s3, ay2_s3;
	logic [DIR_W-1:0]    ax_s3, ay_s3, az_s3;
	logic                sx_s3, sy_s3, sz_s3;
	logic [MARGIN_W-1:0] margin_s3;

	always_ff @(posedge clk) begin
		p2_s3     <= ax2_s2 + az2_s2;
		l2_s3     <= ax2_s2 + ay2_s2 + az2_s2;
		ay2_s3    <= ay2_s2;
		ax_s3     <= ax_s2;
		ay_s3     <= ay_s2;
		az_s3     <= az_s2;
		sx_s3     <= sx_s2;
		sy_s3     <= sy_s2;
		sz_s3     <= sz_s2;
		margin_s3 <= margin_s2;
	end

	// normalization of both lengths, two stages alongside stages 4 and 5
	logic [NORM_LANES-1:0][SQ_W-1:0]   norm_sq;
	logic [NORM_LANES-1:0][NORM_W-1:0] norm_n;
	logic [NORM_LANES-1:0][SH_W-1:0]   norm_sh;

	assign norm_sq[0] = p2_s3;
	assign norm_sq[1] = l2_s3;

	csp_norm #(
		.LANES(NORM_LANES)
	) u_norm (
		.clk(clk),
		.sq (norm_sq),
		.n  (norm_n),
		.sh (norm_sh)
	);

	// stage 4: apex test partial products, sin^2 times each half of l2
	logic [RHS_W-1:0]    rlo_s4, rhi_s4;
	logic [SQ_W-1:0]     ay2_s4;
	logic [DIR_W-1:0]    ax_s4, ay_s4, az_s4;
	logic                sx_s4, sy_s4, sz_s4, p2nz_s4, l2nz_s4;
	logic [MARGIN_W-1:0] margin_s4;

	always_ff @(posedge clk) begin
		rlo_s4    <= RHS_W'(sin2_q) * RHS_W'(l2_s3[31:0]);
		rhi_s4    <= RHS_W'(sin2_q) * RHS_W'(l2_s3[SQ_W-1:32]);
		ay2_s4    <= ay2_s3;
		ax_s4     <= ax_s3;
		ay_s4     <= ay_s3;
		az_s4     <= az_s3;
		sx_s4     <= sx_s3;
		sy_s4     <= sy_s3;
		sz_s4     <= sz_s3;
		p2nz_s4   <= (p2_s3 != '0);
		l2nz_s4   <= (l2_s3 != '0);
		margin_s4 <= margin_s3;
	end

	// stage 5: apex compare, (y * 2^16)^2 against sin^2 * l2
	logic [CMP_W-1:0]    lhs_c, rhs_c;
	logic                apex_s5;
	logic [DIR_W-1:0]    ax_s5, ay_s5, az_s5;
	logic                sx_s5, sy_s5, sz_s5, p2nz_s5, l2nz_s5;
	logic [MARGIN_W-1:0] margin_s5;

	assign lhs_c = {{(CMP_W-SQ_W-32){1'b0}}, ay2_s4, 32'd0};
	assign rhs_c = {rhi_s4, 32'd0} + {32'd0, rlo_s4};

	always_ff @(posedge clk) begin
		apex_s5   <= !sy_s4 && (lhs_c >= rhs_c);
		ax_s5     <= ax_s4;
		ay_s5     <= ay_s4;
		az_s5     <= az_s4;
		sx_s5     <= sx_s4;
		sy_s5     <= sy_s4;
		sz_s5     <= sz_s4;
		p2nz_s5   <= p2nz_s4;
		l2nz_s5   <= l2nz_s4;
		margin_s5 <= margin_s4;
	end

	// numerators and flags ride with the root pipe
	root_tag_t rt_in, rt_out;
	logic      v_root;
	logic [NORM_LANES-1:0][ROOT_W-1:0] root;

	always_comb begin
		rt_in.side.sx     = sx_s5;
		rt_in.side.sy     = sy_s5;
		rt_in.side.sz     = sz_s5;
		rt_in.side.apex   = apex_s5;
		rt_in.side.p2_nz  = p2nz_s5;
		rt_in.side.l2_nz  = l2nz_s5;
		rt_in.side.margin = margin_s5;
		rt_in.num[0]      = num_of(ax_s5, norm_sh[0]);
		rt_in.num[1]      = num_of(az_s5, norm_sh[0]);
		rt_in.num[2]      = num_of(ax_s5, norm_sh[1]);
		rt_in.num[3]      = num_of(ay_s5, norm_sh[1]);
		rt_in.num[4]      = num_of(az_s5, norm_sh[1]);
	end

	csp_isqrt #(
		.LANES(NORM_LANES),
		.TAG_W(ROOT_TAG_W)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s5),
		.rad      (norm_n),
		.tag_in   (rt_in),
		.out_valid(v_root),
		.root     (root),
		.tag_out  (rt_out)
	);

	// unit components: numerator over root
	logic [DIV_LANES-1:0][ROOT_W-1:0] div_den;
	logic [DIV_LANES-1:0][QUO_W-1:0]  quo;
	side_t side_div;

	assign div_den[0] = root[0];
	assign div_den[1] = root[0];
	assign div_den[2] = root[1];
	assign div_den[3] = root[1];
	assign div_den[4] = root[1];

	csp_div #(
		.LANES(DIV_LANES),
		.TAG_W(SIDE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_root),
		.num      (rt_out.num),
		.den      (div_den),
		.tag_in   (rt_out.side),
		.out_valid(v_div),
		.quo      (quo),
		.tag_out  (side_div)
	);

	// stage 6: cap at one and scale by radius or margin
	logic [DIV_LANES-1:0][PROD_W-1:0] prod_s6;
	side_t side_s6;

	always_ff @(posedge clk) begin
		for (int l = 0; l < DIV_LANES; l++) begin
			logic [UNIT_W-1:0] uc;
			logic [CFG_W-1:0]  a;
			uc = (quo[l] > QUO_W'(UNIT_ONE)) ? UNIT_ONE : quo[l][UNIT_W-1:0];
			a  = (l < 2) ? radius_q : side_div.margin;
			prod_s6[l] <= PROD_W'(a) * PROD_W'(uc);
		end
		side_s6 <= side_div;
	end

	// stage 7: round half away from zero, then apply the sign
	logic [PROD_W-1:0] rnd_c [DIV_LANES];
	logic [DIV_LANES-1:0] neg_c;
	logic [DIV_LANES-1:0][VAL_W-1:0] val_s7;
	side_t side_s7;

	assign neg_c = {side_s6.sz, side_s6.sy, side_s6.sx, side_s6.sz, side_s6.sx};

	always_comb begin
		for (int l = 0; l < DIV_LANES; l++) begin
			rnd_c[l] = prod_s6[l] + (PROD_W'(1) << 29);
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < DIV_LANES; l++) begin
			if (neg_c[l]) begin
				val_s7[l] <= ~{1'b0, rnd_c[l][PROD_W-1:30]} + VAL_W'(1);
			end else begin
				val_s7[l] <= {1'b0, rnd_c[l][PROD_W-1:30]};
			end
		end
		side_s7 <= side_s6;
	end

	// output stage: pick the case, add the margin offset, saturate
	logic [SUM_W-1:0]  bx_c, by_c, bz_c, ox_c, oy_c, oz_c;
	logic [CASE_W-1:0] kase_c;
	logic [SUM_W-1:0]  hh_c, rad_c, mrg_c;

	assign hh_c  = {{(SUM_W-CFG_W){1'b0}}, half_height_q};
	assign rad_c = {{(SUM_W-CFG_W){1'b0}}, radius_q};
	assign mrg_c = {{(SUM_W-MARGIN_W){1'b0}}, side_s7.margin};

	always_comb begin
		priority if (side_s7.apex) begin
			bx_c   = '0;
			by_c   = hh_c;
			bz_c   = '0;
			kase_c = CASE_APEX;
		end else if (side_s7.p2_nz) begin
			bx_c   = {{(SUM_W-VAL_W){val_s7[0][VAL_W-1]}}, val_s7[0]};
			by_c   = -hh_c;
			bz_c   = {{(SUM_W-VAL_W){val_s7[1][VAL_W-1]}}, val_s7[1]};
			kase_c = CASE_RIM;
		end else begin
			bx_c   = rad_c;
			by_c   = -hh_c;
			bz_c   = '0;
			kase_c = CASE_AXIAL;
		end
		priority if (side_s7.margin == '0) begin
			ox_c = '0;
			oy_c = '0;
			oz_c = '0;
		end else if (side_s7.l2_nz) begin
			ox_c = {{(SUM_W-VAL_W){val_s7[2][VAL_W-1]}}, val_s7[2]};
			oy_c = {{(SUM_W-VAL_W){val_s7[3][VAL_W-1]}}, val_s7[3]};
			oz_c = {{(SUM_W-VAL_W){val_s7[4][VAL_W-1]}}, val_s7[4]};
		end else begin
			ox_c = '0;
			oy_c = -mrg_c;
			oz_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		point_x    <= sat_pt(bx_c + ox_c);
		point_y    <= sat_pt(by_c + oy_c);
		point_z    <= sat_pt(bz_c + oz_c);
		case_taken <= kase_c;
	end

	// valid bits outside the root and divide units
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_div;
			v_s7 <= v_s6;
			done <= v_s7;
		end
	end

	// checks
	`CSP_ASSERT_LAT(a_word_latency, start && !busy, done, LAT, "accepted word gave no result on time")
	`CSP_ASSERT_IMP(a_no_orphan, done, $past(start && !busy, LAT), "result without an accepted word")
	`CSP_ASSERT_IMP(a_case_code, done, case_taken == CASE_APEX || case_taken == CASE_RIM || case_taken == CASE_AXIAL, "bad case code on a result")

endmodule

// ----- hdl/csp_norm.sv -----
module csp_norm #(
	parameter int LANES = csp_pkg::NORM_LANES
) (
	input  logic                                  clk,
	input  logic [LANES-1:0][csp_pkg::SQ_W-1:0]   sq,
	output logic [LANES-1:0][csp_pkg::NORM_W-1:0] n,
	output logic [LANES-1:0][csp_pkg::SH_W-1:0]   sh
);
	import csp_pkg::*;

	logic [LANES-1:0][SQ_W-1:0] t_s1;
	logic [LANES-1:0][SH_W-1:0] e_s1;
	logic [LANES-1:0]           big_s1;

	// coarse steps: values at or above 2^62 drop by two bits, others move up by 32 and 16
	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			logic [SQ_W-1:0] t;
			logic [SH_W-1:0] e;
			t = sq[l];
			e = SH_W'(30);
			if (sq[l][SQ_W-1:SQ_W-2] != 2'b00) begin
				t = sq[l] >> 2;
				e = SH_W'(29);
			end else begin
				if (t[SQ_W-1:30] == '0) begin
					t = t << 32;
					e = e + SH_W'(16);
				end
				if (t[SQ_W-1:46] == '0) begin
					t = t << 16;
					e = e + SH_W'(8);
				end
			end
			t_s1[l]   <= t;
			e_s1[l]   <= e;
			big_s1[l] <= (sq[l][SQ_W-1:SQ_W-2] != 2'b00);
		end
	end

	// fine steps of 8, 4 and 2 bits
	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			logic [SQ_W-1:0] t;
			logic [SH_W-1:0] e;
			t = t_s1[l];
			e = e_s1[l];
			if (!big_s1[l]) begin
				if (t[SQ_W-1:54] == '0) begin
					t = t << 8;
					e = e + SH_W'(4);
				end
				if (t[SQ_W-1:58] == '0) begin
					t = t << 4;
					e = e + SH_W'(2);
				end
				if (t[SQ_W-1:60] == '0) begin
					t = t << 2;
					e = e + SH_W'(1);
				end
			end
			n[l]  <= t[NORM_W-1:0];
			sh[l] <= e;
		end
	end

endmodule

// ----- hdl/csp_isqrt.sv -----
module csp_isqrt #(
	parameter int LANES = csp_pkg::NORM_LANES,
	parameter int TAG_W = csp_pkg::ROOT_TAG_W
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic [LANES-1:0][csp_pkg::NORM_W-1:0] rad,
	input  logic [TAG_W-1:0]                      tag_in,
	output logic                                  out_valid,
	output logic [LANES-1:0][csp_pkg::ROOT_W-1:0] root,
	output logic [TAG_W-1:0]                      tag_out
);
	import csp_pkg::*;

	localparam int STAGES = ROOT_W;
	localparam int TR_W   = NORM_W + 2;

	logic                       valid_s [0:STAGES];
	logic [LANES-1:0][NORM_W-1:0] rem_s [0:STAGES];
	logic [LANES-1:0][ROOT_W-1:0] root_s [0:STAGES];
	logic [TAG_W-1:0]           tag_s [0:STAGES];

	assign valid_s[0] = in_valid;
	assign rem_s[0]   = rad;
	assign root_s[0]  = '0;
	assign tag_s[0]   = tag_in;

	// one root bit per stage, msb first, remainder kept as n - root^2
	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		localparam int BIT = STAGES - 1 - k;
		logic [LANES-1:0][TR_W-1:0] trial;
		logic [LANES-1:0]           take;

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			assign trial[l] = ({{(TR_W-ROOT_W){1'b0}}, root_s[k][l]} << (BIT + 1))
				| (TR_W'(1) << (2 * BIT));
			assign take[l]  = {2'b00, rem_s[k][l]} >= trial[l];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			tag_s[k+1] <= tag_s[k];
			for (int l = 0; l < LANES; l++) begin
				if (take[l]) begin
					rem_s[k+1][l]  <= rem_s[k][l] - trial[l][NORM_W-1:0];
					root_s[k+1][l] <= root_s[k][l] | (ROOT_W'(1) << BIT);
				end else begin
					rem_s[k+1][l]  <= rem_s[k][l];
					root_s[k+1][l] <= root_s[k][l];
				end
			end
		end
	end

	assign out_valid = valid_s[STAGES];
	assign root      = root_s[STAGES];
	assign tag_out   = tag_s[STAGES];

endmodule

// ----- hdl/csp_div.sv -----
module csp_div #(
	parameter int LANES = csp_pkg::DIV_LANES,
	parameter int TAG_W = csp_pkg::SIDE_W
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic [LANES-1:0][csp_pkg::NUM_W-1:0]  num,
	input  logic [LANES-1:0][csp_pkg::ROOT_W-1:0] den,
	input  logic [TAG_W-1:0]                      tag_in,
	output logic                                  out_valid,
	output logic [LANES-1:0][csp_pkg::QUO_W-1:0]  quo,
	output logic [TAG_W-1:0]                      tag_out
);
	import csp_pkg::*;

	localparam int STAGES = QUO_W;

	logic                          valid_s [0:STAGES];
	logic [LANES-1:0][NUM_W-1:0]   rem_s [0:STAGES];
	logic [LANES-1:0][ROOT_W-1:0]  den_s [0:STAGES];
	logic [LANES-1:0][QUO_W-1:0]   quo_s [0:STAGES];
	logic [TAG_W-1:0]              tag_s [0:STAGES];

	assign valid_s[0] = in_valid;
	assign rem_s[0]   = num;
	assign den_s[0]   = den;
	assign quo_s[0]   = '0;
	assign tag_s[0]   = tag_in;

	// restoring divide, one quotient bit per stage, msb first
	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		localparam int BIT = STAGES - 1 - k;
		logic [LANES-1:0][NUM_W-1:0] dsh;
		logic [LANES-1:0]            take;

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			assign dsh[l]  = {{(NUM_W-ROOT_W){1'b0}}, den_s[k][l]} << BIT;
			assign take[l] = rem_s[k][l] >= dsh[l];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			tag_s[k+1] <= tag_s[k];
			den_s[k+1] <= den_s[k];
			for (int l = 0; l < LANES; l++) begin
				if (take[l]) begin
					rem_s[k+1][l] <= rem_s[k][l] - dsh[l];
					quo_s[k+1][l] <= quo_s[k][l] | (QUO_W'(1) << BIT);
				end else begin
					rem_s[k+1][l] <= rem_s[k][l];
					quo_s[k+1][l] <= quo_s[k][l];
				end
			end
		end
	end

	assign out_valid = valid_s[STAGES];
	assign quo       = quo_s[STAGES];
	assign tag_out   = tag_s[STAGES];

endmodule
